// ===== rtl/pngw_pkg.sv =====
// Shared constants and types for the PNG chunk header walker.
package pngw_pkg;

  localparam int unsigned SigBytes   = 8;
  localparam int unsigned FieldBytes = 4;

  localparam logic [31:0] IendCode = 32'h49454E44;
  localparam logic [63:0] SigReset = 64'h89504E470D0A1A0A;

  localparam logic KindHeader   = 1'b0;
  localparam logic KindSigError = 1'b1;

  typedef struct packed {
    logic        hit;
    logic        kind;
    logic [31:0] length;
    logic [31:0] ctype;
    logic        is_end;
  } pngw_res_t;

endpackage

// ===== rtl/pngw_if.sv =====
// Valid/ready channel interfaces for the PNG chunk header walker.
interface pngw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface pngw_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] chunk_length;
  logic [31:0] chunk_type;
  logic        is_end_chunk;

  modport source (output valid, output result_kind, output chunk_length,
                  output chunk_type, output is_end_chunk, input ready);
  modport sink (input valid, input result_kind, input chunk_length,
                input chunk_type, input is_end_chunk, output ready);
endinterface

interface pngw_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] expected_signature;

  modport source (output valid, output expected_signature, input ready);
  modport sink (input valid, input expected_signature, output ready);
endinterface

// ===== rtl/pngw_walker.sv =====
// Chunk walk state and per-byte next-state and result logic.
module pngw_walker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic                eof_i,
  input  logic [63:0]         sig_i,
  output pngw_pkg::pngw_res_t res_o
);
  import pngw_pkg::*;

  typedef enum logic [2:0] {
    PhSig    = 3'd0,
    PhLen    = 3'd1,
    PhType   = 3'd2,
    PhData   = 3'd3,
    PhCrc    = 3'd4,
    PhIgnore = 3'd5
  } phase_e;

  localparam logic [31:0] FieldLast = 32'(FieldBytes - 1);
  localparam logic [2:0]  SigLast   = 3'(SigBytes - 1);

  phase_e      phase_q, phase_d;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] len_q, len_d;
  logic [31:0] type_q, type_d;
  logic [31:0] type_nx;
  logic [5:0]  sig_sh;
  logic [7:0]  want;
  pngw_res_t   res;

  assign sig_sh  = {SigLast - cnt_q[2:0], 3'b000};
  assign want    = 8'(sig_i >> sig_sh);
  assign type_nx = {type_q[23:0], byte_i};

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    type_d  = type_q;
    res     = '0;
    case (phase_q)
      PhSig: begin
        if (byte_i != want) begin
          res.hit  = 1'b1;
          res.kind = KindSigError;
          phase_d  = PhIgnore;
          cnt_d    = '0;
        end else if (cnt_q[2:0] == SigLast) begin
          phase_d = PhLen;
          cnt_d   = '0;
          len_d   = '0;
        end else begin
          cnt_d = cnt_q + 32'd1;
        end
      end
      PhLen: begin
        len_d = {len_q[23:0], byte_i};
        if (cnt_q == FieldLast) begin
          phase_d = PhType;
          cnt_d   = '0;
          type_d  = '0;
        end else begin
          cnt_d = cnt_q + 32'd1;
        end
      end
      PhType: begin
        type_d = type_nx;
        if (cnt_q == FieldLast) begin
          res.hit    = 1'b1;
          res.kind   = KindHeader;
          res.length = len_q;
          res.ctype  = type_nx;
          res.is_end = (type_nx == IendCode);
          cnt_d      = '0;
          if (type_nx == IendCode) begin
            phase_d = PhIgnore;
          end else if (len_q == '0) begin
            phase_d = PhCrc;
          end else begin
            phase_d = PhData;
          end
        end else begin
          cnt_d = cnt_q + 32'd1;
        end
      end
      PhData: begin
        if (cnt_q + 32'd1 == len_q) begin
          phase_d = PhCrc;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 32'd1;
        end
      end
      PhCrc: begin
        if (cnt_q == FieldLast) begin
          phase_d = PhLen;
          cnt_d   = '0;
          len_d   = '0;
        end else begin
          cnt_d = cnt_q + 32'd1;
        end
      end
      default: begin
      end
    endcase
    if (eof_i) begin
      phase_d = PhSig;
      cnt_d   = '0;
      len_d   = '0;
      type_d  = '0;
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSig;
      cnt_q   <= '0;
      len_q   <= '0;
      type_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      type_q  <= type_d;
    end
  end

endmodule

// ===== rtl/png_chunk_header_walker_top.sv =====
// Top level of the PNG chunk header walker: channel registers and config.
//
// Channel  Dir  Payload                                             Accepted when
// in_ch    in   data_byte[7:0], end_of_file                         valid & ready
// out_ch   out  result_kind, chunk_length, chunk_type, is_end_chunk  valid & ready
// cfg_ch   in   expected_signature[63:0]                            valid & ready
//
// One byte per cycle sustained while out_ch is not stalled. A byte is held in the
// input register, then the walker updates its state and loads the result register.
// Reset restores the default signature and the signature phase.
// A stalled result stalls the input register and the walker; cfg_ch is always ready.
module png_chunk_header_walker_top (
  input  logic clk_i,
  input  logic rst_ni,
  pngw_in_if.sink    in_ch,
  pngw_out_if.source out_ch,
  pngw_cfg_if.sink   cfg_ch
);
  import pngw_pkg::*;

  logic        sig_we;
  logic [63:0] sig_q;
  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        in_eof_q;
  logic        adv;
  pngw_res_t   res;
  logic        out_vld_q;
  logic        out_kind_q;
  logic [31:0] out_len_q;
  logic [31:0] out_type_q;
  logic        out_end_q;

  assign adv          = in_vld_q && (!out_vld_q || out_ch.ready);
  assign in_ch.ready  = !in_vld_q || adv;
  assign cfg_ch.ready = 1'b1;
  assign sig_we       = cfg_ch.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_q <= SigReset;
    end else if (sig_we) begin
      sig_q <= cfg_ch.expected_signature;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_q <= in_ch.data_byte;
      in_eof_q  <= in_ch.end_of_file;
    end
  end

  pngw_walker u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .byte_i (in_byte_q),
    .eof_i  (in_eof_q),
    .sig_i  (sig_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= res.hit;
    end else if (out_ch.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res.hit) begin
      out_kind_q <= res.kind;
      out_len_q  <= res.length;
      out_type_q <= res.ctype;
      out_end_q  <= res.is_end;
    end
  end

  assign out_ch.valid        = out_vld_q;
  assign out_ch.result_kind  = out_kind_q;
  assign out_ch.chunk_length = out_len_q;
  assign out_ch.chunk_type   = out_type_q;
  assign out_ch.is_end_chunk = out_end_q;

endmodule
